// ===== hw/rtl/i2cbe_pkg.sv =====
// shared types and constants of the i2c master byte engine
`default_nettype none

package i2cbe_pkg;

  typedef enum logic [1:0] {
    CMD_START = 2'd0,
    CMD_WRITE = 2'd1,
    CMD_READ  = 2'd2,
    CMD_STOP  = 2'd3
  } cmd_kind_e;

  localparam int unsigned StepW = 5;

  localparam logic [StepW-1:0] FinalStart    = StepW'(20);
  localparam logic [StepW-1:0] FinalWrite    = StepW'(19);
  localparam logic [StepW-1:0] FinalReadNack = StepW'(19);
  localparam logic [StepW-1:0] FinalReadAck  = StepW'(18);
  localparam logic [StepW-1:0] FinalStop     = StepW'(1);

  typedef struct packed {
    cmd_kind_e        kind;
    logic [7:0]       data;
    logic             last;
    logic [8:0]       bus;
    logic [StepW-1:0] final_step;
  } cmd_t;

endpackage

`default_nettype wire

// ===== hw/rtl/i2cbe_front.sv =====
// front stage: takes command items and classifies them
`default_nettype none

module i2cbe_front
  import i2cbe_pkg::*;
(
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  input  wire logic [23:0] s_axis_tdata,   // data_byte[7:0], bus_levels[16:8], zero pad
  input  wire logic [1:0]  s_axis_tuser,   // action[1:0]
  input  wire logic        s_axis_tlast,   // last_read
  output logic             cmd_valid_o,
  output cmd_t             cmd_o,
  input  wire logic        cmd_ready_i
);

  logic valid_q, valid_d;
  cmd_t cmd_q, cmd_d;
  logic take;

  assign s_axis_tready = !valid_q || cmd_ready_i;
  assign take          = s_axis_tvalid && s_axis_tready;

  always_comb begin
    valid_d = valid_q;
    cmd_d   = cmd_q;
    if (cmd_ready_i) begin
      valid_d = 1'b0;
    end
    if (take) begin
      valid_d      = 1'b1;
      cmd_d.kind   = cmd_kind_e'(s_axis_tuser);
      cmd_d.data   = s_axis_tdata[7:0];
      cmd_d.bus    = s_axis_tdata[16:8];
      cmd_d.last   = s_axis_tlast;
      case (cmd_kind_e'(s_axis_tuser))
        CMD_START: cmd_d.final_step = FinalStart;
        CMD_WRITE: cmd_d.final_step = FinalWrite;
        CMD_READ:  cmd_d.final_step = s_axis_tlast ? FinalReadNack : FinalReadAck;
        CMD_STOP:  cmd_d.final_step = FinalStop;
        default:   cmd_d.final_step = FinalStop;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cmd_q <= cmd_d;
  end

  assign cmd_valid_o = valid_q;
  assign cmd_o       = cmd_q;

endmodule

`default_nettype wire

// ===== hw/rtl/i2cbe_queue.sv =====
// short command queue between front and back
`default_nettype none

module i2cbe_queue
  import i2cbe_pkg::*;
#(
  parameter int unsigned Depth = 2
) (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  input  wire logic in_valid_i,
  output logic      in_ready_o,
  input  wire cmd_t in_cmd_i,
  output logic      out_valid_o,
  output cmd_t      out_cmd_o,
  input  wire logic out_ready_i
);

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);

  cmd_t mem_q [Depth];
  logic [PtrW-1:0] wr_q, wr_d, rd_q, rd_d;
  logic [CntW-1:0] cnt_q, cnt_d;
  logic push, pop;

  assign in_ready_o  = cnt_q != CntW'(Depth);
  assign out_valid_o = cnt_q != '0;
  assign out_cmd_o   = mem_q[rd_q];
  assign push        = in_valid_i && in_ready_o;
  assign pop         = out_valid_o && out_ready_i;

  always_comb begin
    wr_d  = wr_q;
    rd_d  = rd_q;
    cnt_d = cnt_q;
    if (push) begin
      wr_d = (wr_q == PtrW'(Depth - 1)) ? '0 : wr_q + PtrW'(1);
    end
    if (pop) begin
      rd_d = (rd_q == PtrW'(Depth - 1)) ? '0 : rd_q + PtrW'(1);
    end
    if (push && !pop) begin
      cnt_d = cnt_q + CntW'(1);
    end else if (pop && !push) begin
      cnt_d = cnt_q - CntW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wr_q] <= in_cmd_i;
    end
  end

endmodule

`default_nettype wire

// ===== hw/rtl/i2cbe_back.sv =====
// back stage: plays each command out as a run of bus phases
`default_nettype none

module i2cbe_back
  import i2cbe_pkg::*;
(
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        cmd_valid_i,
  input  wire cmd_t        cmd_i,
  output logic             cmd_ready_o,
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  output logic [15:0]      m_axis_tdata,   // scl_level[0], sda_level[1], read_byte[9:2],
                                           // ack_seen[10], zero pad
  output logic             m_axis_tlast    // final_phase
);

  logic             scl_q, scl_d, sda_q, sda_d;
  logic [StepW-1:0] step_q, step_d;
  logic             ovalid_q, ovalid_d;
  logic             oscl_q, osda_q, oack_q, ofin_q;
  logic [7:0]       obyte_q;

  logic             adv, fin;
  logic             emit_sda;
  logic [StepW-1:0] wstep, jstep;
  logic [2:0]       bit_i;
  logic [7:0]       shifted;
  logic             next_bit;

  assign adv         = cmd_valid_i && (!ovalid_q || m_axis_tready);
  assign fin         = step_q == cmd_i.final_step;
  assign cmd_ready_o = adv && fin;

  always_comb begin
    wstep    = (cmd_i.kind == CMD_START) ? step_q - StepW'(1) : step_q;
    jstep    = wstep - StepW'(1);
    bit_i    = jstep[3:1];
    shifted  = cmd_i.data << ({1'b0, bit_i} + 4'd1);
    next_bit = (bit_i == 3'd7) ? 1'b1 : shifted[7];

    emit_sda = sda_q;
    scl_d    = scl_q;
    sda_d    = sda_q;

    case (cmd_i.kind)
      CMD_START, CMD_WRITE: begin
        if (cmd_i.kind == CMD_START && step_q == '0) begin
          sda_d = 1'b0;
        end else if (wstep == '0) begin
          scl_d = 1'b0;
          sda_d = cmd_i.data[7];
        end else if (wstep <= StepW'(16)) begin
          if (!jstep[0]) begin
            scl_d = 1'b1;
          end else begin
            scl_d = 1'b0;
            sda_d = next_bit;
          end
        end else if (wstep == StepW'(17)) begin
          scl_d = 1'b1;
          sda_d = 1'b1;
        end else if (wstep == StepW'(18)) begin
          scl_d = 1'b0;
        end
      end
      CMD_READ: begin
        if (step_q <= StepW'(15)) begin
          if (!step_q[0]) begin
            scl_d = 1'b1;
            sda_d = 1'b1;
          end else begin
            scl_d = 1'b0;
            if (step_q == StepW'(15)) begin
              sda_d = cmd_i.last;
            end
          end
        end else if (step_q == StepW'(16)) begin
          scl_d = 1'b1;
        end else if (step_q == StepW'(17)) begin
          scl_d = 1'b0;
          sda_d = !cmd_i.last;
        end else if (step_q == StepW'(18) && cmd_i.last) begin
          scl_d = 1'b1;
          sda_d = 1'b1;
        end
      end
      CMD_STOP: begin
        if (step_q == '0) begin
          emit_sda = 1'b0;
          scl_d    = 1'b1;
          sda_d    = 1'b1;
        end
      end
      default: begin
        scl_d = scl_q;
      end
    endcase

    step_d   = step_q;
    ovalid_d = ovalid_q && !m_axis_tready;
    if (adv) begin
      ovalid_d = 1'b1;
      step_d   = fin ? '0 : step_q + StepW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      scl_q    <= 1'b1;
      sda_q    <= 1'b1;
      step_q   <= '0;
      ovalid_q <= 1'b0;
    end else begin
      ovalid_q <= ovalid_d;
      step_q   <= step_d;
      if (adv) begin
        scl_q <= scl_d;
        sda_q <= sda_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      oscl_q  <= scl_q;
      osda_q  <= emit_sda;
      ofin_q  <= fin;
      obyte_q <= (fin && cmd_i.kind == CMD_READ) ? cmd_i.bus[8:1] : 8'd0;
      oack_q  <= fin && (cmd_i.kind == CMD_START || cmd_i.kind == CMD_WRITE)
                 && !cmd_i.bus[0];
    end
  end

  assign m_axis_tvalid = ovalid_q;
  assign m_axis_tdata  = {5'd0, oack_q, obyte_q, osda_q, oscl_q};
  assign m_axis_tlast  = ofin_q;

endmodule

`default_nettype wire

// ===== hw/rtl/i2c_master_byte_engine.sv =====
// top level of the i2c master byte engine
// a command passes the front register and a queue entry before its first phase item is registered at the output
// throughput: one phase item per cycle while a command waits and m_axis_tready does not stall the output;
//   a command runs the phase sequencer for 21 (start), 20 (write), 19 or 20 (read) or 2 (stop) phase items
// commands are taken while the sequencer works, up to QueueDepth + 1 held with the running one
// reset: both lines released high, queue and output register empty
`default_nettype none

module i2c_master_byte_engine
  import i2cbe_pkg::*;
#(
  parameter int unsigned QueueDepth = 2
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  input  wire logic [23:0] s_axis_tdata,   // data_byte[7:0], bus_levels[16:8], zero pad
  input  wire logic [1:0]  s_axis_tuser,   // action[1:0]
  input  wire logic        s_axis_tlast,   // last_read
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  output logic [15:0]      m_axis_tdata,   // scl_level[0], sda_level[1], read_byte[9:2],
                                           // ack_seen[10], zero pad
  output logic             m_axis_tlast    // final_phase
);

  logic f_valid, f_ready, q_valid, q_ready;
  cmd_t f_cmd, q_cmd;

  i2cbe_front u_front (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .s_axis_tlast  (s_axis_tlast),
    .cmd_valid_o   (f_valid),
    .cmd_o         (f_cmd),
    .cmd_ready_i   (f_ready)
  );

  i2cbe_queue #(
    .Depth (QueueDepth)
  ) u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (f_valid),
    .in_ready_o  (f_ready),
    .in_cmd_i    (f_cmd),
    .out_valid_o (q_valid),
    .out_cmd_o   (q_cmd),
    .out_ready_i (q_ready)
  );

  i2cbe_back u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cmd_valid_i   (q_valid),
    .cmd_i         (q_cmd),
    .cmd_ready_o   (q_ready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast)
  );

endmodule

`default_nettype wire

// ===== hw/rtl/i2cbe_checker.sv =====
// port checker for the i2c master byte engine and its bind
`default_nettype none

module i2cbe_checker (
  input wire logic        clk_i,
  input wire logic        rst_ni,
  input wire logic        s_axis_tvalid,
  input wire logic        s_axis_tready,
  input wire logic [23:0] s_axis_tdata,
  input wire logic [1:0]  s_axis_tuser,
  input wire logic        s_axis_tlast,
  input wire logic        m_axis_tvalid,
  input wire logic        m_axis_tready,
  input wire logic [15:0] m_axis_tdata,
  input wire logic        m_axis_tlast
);

  logic in_fire;
  assign in_fire = s_axis_tvalid && s_axis_tready && (s_axis_tuser != 2'd0 || s_axis_tlast
                   || s_axis_tdata != 24'd0 || 1'b1);

  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid)
    else $error("output item dropped while stalled");

  a_final_release: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tlast |-> m_axis_tdata[1])
    else $error("sda not released on final phase");

  a_result_on_final: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tlast |-> m_axis_tdata[10:2] == 9'd0)
    else $error("read data or ack outside final phase");

  a_byte_or_ack: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> !(m_axis_tdata[10] && (m_axis_tdata[9:2] != 8'd0)))
    else $error("read data and ack in one item");

  a_no_early_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(rst_ni) |-> !m_axis_tvalid || in_fire)
    else $error("output item without a command");

endmodule

bind i2c_master_byte_engine i2cbe_checker u_chk (.*);

`default_nettype wire

// ===== sim/tb.sv =====
`timescale 1ns / 100ps
// self-checking testbench of the i2c master byte engine, directed table then random commands
module tb;
  import i2cbe_pkg::*;

  localparam int unsigned ItemTarget  = 310;
  localparam int unsigned CycleLimit  = 400000;
  localparam int unsigned DrainCycles = 30;

  typedef struct packed {
    logic       scl;
    logic       sda;
    logic [7:0] rb;
    logic       ack;
    logic       fin;
  } bus_phase_t;

  // known set: the final phase of the command is typed in below
  typedef struct packed {
    cmd_kind_e  kind;
    logic [7:0] data;
    logic       last;
    logic [8:0] bus;
    logic       known;
    logic       scl;
    logic       sda;
    logic [7:0] rb;
    logic       ack;
  } cmd_row_t;

  localparam int unsigned NumRows = 18;
  localparam cmd_row_t CmdTable [NumRows] = '{
    '{CMD_STOP,  8'h00, 1'b0, 9'h000, 1'b1, 1'b1, 1'b1, 8'h00, 1'b0},
    '{CMD_START, 8'h00, 1'b0, 9'h000, 1'b1, 1'b0, 1'b1, 8'h00, 1'b1},
    '{CMD_WRITE, 8'hFF, 1'b1, 9'h1FF, 1'b1, 1'b0, 1'b1, 8'h00, 1'b0},
    '{CMD_WRITE, 8'hA5, 1'b0, 9'h1FE, 1'b1, 1'b0, 1'b1, 8'h00, 1'b1},
    '{CMD_READ,  8'h00, 1'b0, 9'h1FF, 1'b1, 1'b0, 1'b1, 8'hFF, 1'b0},
    '{CMD_READ,  8'hFF, 1'b0, 9'h001, 1'b1, 1'b0, 1'b1, 8'h00, 1'b0},
    '{CMD_READ,  8'h3C, 1'b1, 9'h154, 1'b1, 1'b1, 1'b1, 8'hAA, 1'b0},
    '{CMD_STOP,  8'h00, 1'b0, 9'h000, 1'b1, 1'b1, 1'b1, 8'h00, 1'b0},
    '{CMD_START, 8'hFF, 1'b0, 9'h1FF, 1'b1, 1'b0, 1'b1, 8'h00, 1'b0},
    '{CMD_START, 8'h5A, 1'b0, 9'h0FE, 1'b1, 1'b0, 1'b1, 8'h00, 1'b1},
    '{CMD_READ,  8'h00, 1'b1, 9'h000, 1'b1, 1'b1, 1'b1, 8'h00, 1'b0},
    '{CMD_WRITE, 8'h3C, 1'b0, 9'h0AB, 1'b0, 1'b0, 1'b0, 8'h00, 1'b0},
    '{CMD_START, 8'h81, 1'b1, 9'h155, 1'b0, 1'b0, 1'b0, 8'h00, 1'b0},
    '{CMD_READ,  8'h7E, 1'b0, 9'h0AA, 1'b0, 1'b0, 1'b0, 8'h00, 1'b0},
    '{CMD_STOP,  8'hFF, 1'b1, 9'h1FF, 1'b1, 1'b1, 1'b1, 8'h00, 1'b0},
    '{CMD_STOP,  8'h00, 1'b0, 9'h000, 1'b0, 1'b0, 1'b0, 8'h00, 1'b0},
    '{CMD_WRITE, 8'h00, 1'b0, 9'h001, 1'b1, 1'b0, 1'b1, 8'h00, 1'b0},
    '{CMD_READ,  8'h00, 1'b1, 9'h155, 1'b0, 1'b0, 1'b0, 8'h00, 1'b0}
  };

  logic        clk_i;
  logic        rst_ni;
  logic        s_axis_tvalid;
  logic        s_axis_tready;
  logic [23:0] s_axis_tdata;
  logic [1:0]  s_axis_tuser;
  logic        s_axis_tlast;
  logic        m_axis_tvalid;
  logic        m_axis_tready;
  logic [15:0] m_axis_tdata;
  logic        m_axis_tlast;

  logic        scl_line;
  logic        sda_line;
  bus_phase_t  phase_q [$];

  int unsigned sent_cnt;
  int unsigned phase_cnt;
  int unsigned err_cnt;
  int unsigned cycle_cnt;
  int unsigned send_gap_pct;
  int unsigned sink_stall_pct;

  i2c_master_byte_engine dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .s_axis_tlast  (s_axis_tlast),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast)
  );

  initial begin
    clk_i = 1'b0;
    forever #10 clk_i = ~clk_i;
  end

  task automatic emit_phase(input logic [7:0] rb, input logic ack, input logic fin);
    bus_phase_t p;
    p.scl = scl_line;
    p.sda = sda_line;
    p.rb  = rb;
    p.ack = ack;
    p.fin = fin;
    phase_q.push_back(p);
  endtask

  task automatic predict_shift_out(input logic [7:0] data, input logic [8:0] bus);
    emit_phase(8'h00, 1'b0, 1'b0);
    scl_line = 1'b0;
    for (int i = 7; i >= 0; i--) begin
      sda_line = data[i];
      emit_phase(8'h00, 1'b0, 1'b0);
      scl_line = 1'b1;
      emit_phase(8'h00, 1'b0, 1'b0);
      scl_line = 1'b0;
    end
    sda_line = 1'b1;
    emit_phase(8'h00, 1'b0, 1'b0);
    scl_line = 1'b1;
    emit_phase(8'h00, 1'b0, 1'b0);
    scl_line = 1'b0;
    emit_phase(8'h00, ~bus[0], 1'b1);
  endtask

  task automatic predict_shift_in(input logic nack, input logic [8:0] bus);
    logic [7:0] got;
    got = 8'h00;
    for (int i = 7; i >= 0; i--) begin
      emit_phase(8'h00, 1'b0, 1'b0);
      scl_line = 1'b1;
      sda_line = 1'b1;
      got[i]   = bus[i+1];
      emit_phase(8'h00, 1'b0, 1'b0);
      scl_line = 1'b0;
    end
    sda_line = nack;
    emit_phase(8'h00, 1'b0, 1'b0);
    scl_line = 1'b1;
    emit_phase(8'h00, 1'b0, 1'b0);
    scl_line = 1'b0;
    // nack is followed by a stop condition
    if (nack) begin
      sda_line = 1'b0;
      emit_phase(8'h00, 1'b0, 1'b0);
      scl_line = 1'b1;
    end
    sda_line = 1'b1;
    emit_phase(got, 1'b0, 1'b1);
  endtask

  task automatic predict_command(input cmd_row_t row);
    case (row.kind)
      CMD_START: begin
        emit_phase(8'h00, 1'b0, 1'b0);
        sda_line = 1'b0;
        predict_shift_out(row.data, row.bus);
      end
      CMD_WRITE: predict_shift_out(row.data, row.bus);
      CMD_READ:  predict_shift_in(row.last, row.bus);
      default: begin
        sda_line = 1'b0;
        emit_phase(8'h00, 1'b0, 1'b0);
        scl_line = 1'b1;
        sda_line = 1'b1;
        emit_phase(8'h00, 1'b0, 1'b1);
      end
    endcase
  endtask

  task automatic issue_command(input cmd_row_t row);
    bus_phase_t p;
    if (sent_cnt < 110) begin
      send_gap_pct   = 26;
      sink_stall_pct = 57;
    end else if (sent_cnt < 210) begin
      send_gap_pct   = 57;
      sink_stall_pct = 26;
    end else begin
      send_gap_pct   = 0;
      sink_stall_pct = 0;
    end
    while ($urandom_range(0, 99) < send_gap_pct) begin
      s_axis_tvalid <= 1'b0;
      @(negedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= row.kind;
    s_axis_tdata  <= {7'd0, row.bus, row.data};
    s_axis_tlast  <= row.last;
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    predict_command(row);
    if (row.known) begin
      p     = phase_q.pop_back();
      p.scl = row.scl;
      p.sda = row.sda;
      p.rb  = row.rb;
      p.ack = row.ack;
      phase_q.push_back(p);
    end
    sent_cnt++;
    @(negedge clk_i);
  endtask

  task automatic issue_random(input cmd_kind_e kind, input logic [7:0] data, input logic last);
    cmd_row_t r;
    r      = '0;
    r.kind = kind;
    r.data = data;
    r.last = last;
    r.bus  = 9'($urandom_range(0, 511));
    issue_command(r);
  endtask

  task automatic report_mismatch(input string what, input int unsigned got,
                                 input int unsigned want);
    $display("%0t: phase item %0d, %s got 'h%0h expected 'h%0h",
             $time, phase_cnt, what, got, want);
    err_cnt++;
  endtask

  always @(posedge clk_i) begin
    bus_phase_t want;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      if (phase_q.size() == 0) begin
        report_mismatch("item with none expected", 1, 0);
      end else begin
        want = phase_q.pop_front();
        if (m_axis_tdata[0] !== want.scl)
          report_mismatch("scl_level", 32'(m_axis_tdata[0]), 32'(want.scl));
        if (m_axis_tdata[1] !== want.sda)
          report_mismatch("sda_level", 32'(m_axis_tdata[1]), 32'(want.sda));
        if (m_axis_tdata[9:2] !== want.rb)
          report_mismatch("read_byte", 32'(m_axis_tdata[9:2]), 32'(want.rb));
        if (m_axis_tdata[10] !== want.ack)
          report_mismatch("ack_seen", 32'(m_axis_tdata[10]), 32'(want.ack));
        if (m_axis_tlast !== want.fin)
          report_mismatch("final_phase", 32'(m_axis_tlast), 32'(want.fin));
      end
      phase_cnt++;
    end
  end

  initial begin
    m_axis_tready = 1'b0;
    forever begin
      @(negedge clk_i);
      m_axis_tready <= ($urandom_range(0, 99) >= sink_stall_pct);
    end
  end

  always @(posedge clk_i) begin
    cycle_cnt++;
    if (cycle_cnt >= CycleLimit) begin
      $display("timeout after %0d cycles", cycle_cnt);
      $display("i2c_master_byte_engine regression: fail");
      $finish;
    end
  end

  initial begin
    logic [7:0]  addr;
    int unsigned n;
    logic        nack;
    rst_ni         = 1'b0;
    s_axis_tvalid  = 1'b0;
    s_axis_tdata   = '0;
    s_axis_tuser   = CMD_START;
    s_axis_tlast   = 1'b0;
    scl_line       = 1'b1;
    sda_line       = 1'b1;
    sent_cnt       = 0;
    phase_cnt      = 0;
    err_cnt        = 0;
    cycle_cnt      = 0;
    send_gap_pct   = 26;
    sink_stall_pct = 57;
    repeat (9) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    foreach (CmdTable[i]) issue_command(CmdTable[i]);

    while (sent_cnt < ItemTarget) begin
      if ($urandom_range(0, 9) < 8) begin
        // address, one to four data bytes, then a stop (always after writes, sometimes after reads)
        addr = 8'($urandom_range(0, 255));
        issue_random(CMD_START, addr, 1'($urandom_range(0, 1)));
        n = $urandom_range(1, 4);
        for (int k = 0; k < n; k++) begin
          if (addr[0]) begin
            nack = (k == n - 1);
            issue_random(CMD_READ, 8'($urandom_range(0, 255)), nack);
          end else begin
            issue_random(CMD_WRITE, 8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
          end
        end
        if (!addr[0] || $urandom_range(0, 3) == 0)
          issue_random(CMD_STOP, 8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
      end else begin
        n = $urandom_range(1, 4);
        repeat (n) issue_random(cmd_kind_e'($urandom_range(0, 3)),
                                8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
      end
    end
    s_axis_tvalid <= 1'b0;

    while (phase_q.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
    if (err_cnt == 0) begin
      $display("i2c_master_byte_engine regression: pass");
    end else begin
      $display("i2c_master_byte_engine regression: fail");
    end
    $finish;
  end

endmodule
